@@ rtl/core/pprd_pkg.sv @@
// Package for the pulse peak rate detector: field widths, register codes,
// reset values and the transaction types shared by the core, front and back. No dependencies.
`timescale 1ns / 1ps

package pprd_pkg;

  localparam int SAMPLE_W  = 18;
  localparam int TIME_W    = 48;
  localparam int RATE_W    = 16;
  localparam int INTV_W    = 24;
  localparam int THR_W     = 8;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_NUM_W = 26;
  localparam int DIV_DEN_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_DIVISOR  = 2'd2;

  localparam logic [INTV_W-1:0]    MIN_INTERVAL_RST = 24'd250000;
  localparam logic [INTV_W-1:0]    MAX_INTERVAL_RST = 24'd2000000;
  localparam logic [THR_W-1:0]     THR_DIVISOR_RST  = 8'd18;
  localparam logic [DIV_NUM_W-1:0] RATE_NUMERATOR   = 26'd60000000;
  localparam logic [RATE_W-1:0]    RATE_MAX         = 16'hFFFF;

  typedef struct packed {
    logic [SAMPLE_W-1:0] ir_sample;
    logic [TIME_W-1:0]   timestamp_us;
  } in_item_t;

  typedef struct packed {
    logic                peak_flag;
    logic                rate_update;
    logic [RATE_W-1:0]   raw_rate;
    logic [RATE_W-1:0]   smoothed_rate;
    logic [RATE_W-1:0]   held_rate;
    logic [SAMPLE_W-1:0] dc_level_out;
  } out_item_t;

  // Classified sample handed from the front to the back.
  typedef struct packed {
    logic                peak;
    logic                update;
    logic [INTV_W-1:0]   interval;
    logic [SAMPLE_W-1:0] dc_level;
  } peak_item_t;

endpackage

@@ rtl/core/pulse_peak_rate_detector_core.sv @@
// Top level of the pulse peak rate detector: front end, classified-sample queue,
// back end and result queue. Depends on pprd_pkg, pprd_front, pprd_fifo, pprd_back.
//
//   channel  direction  handshake            payload
//   input    in         push / full          in_item_i  (ir_sample, timestamp_us)
//   result   out        empty / pop          out_item_o (flags, rates, dc level)
//   config   in         cfg_we_i             cfg_idx_i, cfg_data_i
//
// The front takes a new sample only once it has handed on the last one. A sample
// without a rate update leaves the back in the cycle it is taken; one with an
// update waits for the rate division, history summing and the mean division.
// Reset clears the control state at once, with no clearing pass.
// A full result queue stalls the back, then the middle queue, then push.
`timescale 1ns / 1ps

module pulse_peak_rate_detector_core #(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pprd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pprd_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           push,
  input  pprd_pkg::in_item_t             in_item_i,
  output logic                           full,
  output logic                           empty,
  input  logic                           pop,
  output pprd_pkg::out_item_t            out_item_o
);

  pprd_pkg::peak_item_t front_item, mid_item;
  pprd_pkg::out_item_t  back_item;
  logic front_valid, mid_full, mid_empty, mid_pop;
  logic out_full, out_push;

  pprd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .push_i       (push),
    .in_item_i    (in_item_i),
    .busy_o       (full),
    .item_o       (front_item),
    .item_valid_o (front_valid),
    .item_ready_i (!mid_full)
  );

  pprd_fifo #(
    .WIDTH ($bits(pprd_pkg::peak_item_t)),
    .DEPTH (4)
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .wdata_i (front_item),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (mid_item),
    .empty_o (mid_empty)
  );

  pprd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (mid_item),
    .item_valid_i (!mid_empty),
    .item_pop_o   (mid_pop),
    .out_full_i   (out_full),
    .out_push_o   (out_push),
    .out_item_o   (back_item)
  );

  pprd_fifo #(
    .WIDTH ($bits(pprd_pkg::out_item_t)),
    .DEPTH (2)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (back_item),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_item_o),
    .empty_o (empty)
  );

endmodule

@@ rtl/core/pprd_fifo.sv @@
// Small generic first-in first-out queue of flat words.
// No dependencies.
`timescale 1ns / 1ps

module pprd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

@@ rtl/core/pprd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module pprd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/pprd_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps

module pprd_divider #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o,
  output logic             done_o
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   shifted;
  logic             ge;

  assign shifted = {rem_q, num_q[NUM_W-1]};
  assign ge      = (shifted >= {1'b0, den_q});
  assign quo_o   = num_q;
  assign done_o  = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The dividend register shifts out from the top while quotient bits enter at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], ge};
      rem_q <= ge ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
    end
  end

endmodule

@@ rtl/core/pprd_front.sv @@
// Front end: configuration registers, DC tracking filter and peak classification.
// Depends on pprd_pkg.
`timescale 1ns / 1ps

module pprd_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pprd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pprd_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           push_i,
  input  pprd_pkg::in_item_t             in_item_i,
  output logic                           busy_o,
  output pprd_pkg::peak_item_t           item_o,
  output logic                           item_valid_o,
  input  logic                           item_ready_i
);

  typedef enum logic {ST_IDLE, ST_CLASS} state_e;

  localparam int SW = pprd_pkg::SAMPLE_W;
  localparam int TW = pprd_pkg::TIME_W;
  localparam int MW = SW + 6;
  localparam int PW = SW + pprd_pkg::THR_W;

  state_e                       state_q;
  logic [pprd_pkg::INTV_W-1:0]  min_q, max_q;
  logic [pprd_pkg::THR_W-1:0]   thr_q;
  logic [SW-1:0]                dc_q, prev_q, smp_q;
  logic [TW-1:0]                last_q, now_q;
  logic                         was_above_q;

  logic                         accept;
  logic [MW-1:0]                mix;
  logic [SW-1:0]                dc_d;
  logic [SW-1:0]                ac;
  logic [pprd_pkg::THR_W-1:0]   div_sel;
  logic [PW-1:0]                prod;
  logic                         above, peak, in_bounds;
  logic [TW-1:0]                interval;

  assign accept = push_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // dc * 31 + sample, then divided by 32
  assign mix  = (MW'(in_item_i.ir_sample) + (MW'(dc_q) << 5)) - MW'(dc_q);
  assign dc_d = (dc_q == '0) ? in_item_i.ir_sample : mix[SW+4:5];

  // ac > floor(dc / div) is the same test as ac * div > dc
  assign ac       = (smp_q > dc_q) ? smp_q - dc_q : '0;
  assign div_sel  = (thr_q == '0) ? pprd_pkg::THR_W'(1) : thr_q;
  assign prod     = PW'(ac) * PW'(div_sel);
  assign above    = (prod > PW'(dc_q)) && (smp_q > prev_q);
  assign peak     = above && !was_above_q;
  assign interval = now_q - last_q;
  assign in_bounds = (interval > TW'(min_q)) && (interval < TW'(max_q));

  assign item_valid_o    = (state_q == ST_CLASS);
  assign item_o.peak     = peak;
  assign item_o.update   = peak && (last_q != '0) && in_bounds;
  assign item_o.interval = interval[pprd_pkg::INTV_W-1:0];
  assign item_o.dc_level = dc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      min_q       <= pprd_pkg::MIN_INTERVAL_RST;
      max_q       <= pprd_pkg::MAX_INTERVAL_RST;
      thr_q       <= pprd_pkg::THR_DIVISOR_RST;
      dc_q        <= '0;
      prev_q      <= '0;
      last_q      <= '0;
      was_above_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pprd_pkg::CFG_MIN_INTERVAL: min_q <= cfg_data_i;
          pprd_pkg::CFG_MAX_INTERVAL: max_q <= cfg_data_i;
          pprd_pkg::CFG_THR_DIVISOR:  thr_q <= cfg_data_i[pprd_pkg::THR_W-1:0];
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            dc_q    <= dc_d;
            state_q <= ST_CLASS;
          end
        end
        ST_CLASS: begin
          if (item_ready_i) begin
            was_above_q <= above;
            prev_q      <= smp_q;
            if (peak) begin
              last_q <= now_q;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q <= in_item_i.ir_sample;
      now_q <= in_item_i.timestamp_us;
    end
  end

endmodule

@@ rtl/core/pprd_back.sv @@
// Back end: rate division, rate history and mean, result assembly.
// Depends on pprd_pkg, pprd_divider and pprd_ram.
`timescale 1ns / 1ps

module pprd_back #(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pprd_pkg::peak_item_t   item_i,
  input  logic                   item_valid_i,
  output logic                   item_pop_o,
  input  logic                   out_full_i,
  output logic                   out_push_o,
  output pprd_pkg::out_item_t    out_item_o
);

  typedef enum logic [1:0] {B_IDLE, B_RATE, B_SUM, B_MEAN} state_e;

  localparam int AW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FW    = $clog2(HISTORY_DEPTH + 1);
  localparam int RW    = pprd_pkg::RATE_W;
  localparam int SUM_W = RW + FW;
  localparam int NW    = pprd_pkg::DIV_NUM_W;
  localparam int DW    = pprd_pkg::DIV_DEN_W;

  state_e               state_q;
  pprd_pkg::peak_item_t cur_q;
  logic [RW-1:0]        raw_q, latest_q;
  logic [AW-1:0]        widx_q;
  logic [FW-1:0]        fill_q, sidx_q;
  logic [SUM_W-1:0]     sum_q;
  logic                 rvalid_q;

  logic                 take, div_start, div_done, rd_en, sum_done, ram_we;
  logic [NW-1:0]        div_num, div_quo;
  logic [DW-1:0]        div_den;
  logic [RW-1:0]        raw_sat, ram_rdata;

  assign take       = (state_q == B_IDLE) && item_valid_i && !out_full_i;
  assign item_pop_o = take;
  assign rd_en      = (state_q == B_SUM) && (sidx_q < fill_q);
  assign sum_done   = (state_q == B_SUM) && !rd_en && !rvalid_q;
  assign div_start  = (take && item_i.update) || sum_done;
  assign div_num    = (state_q == B_IDLE) ? pprd_pkg::RATE_NUMERATOR : NW'(sum_q);
  assign div_den    = (state_q == B_IDLE) ? DW'(item_i.interval) : DW'(fill_q);
  assign raw_sat    = (div_quo > NW'(pprd_pkg::RATE_MAX)) ? pprd_pkg::RATE_MAX
                                                           : div_quo[RW-1:0];
  assign ram_we     = (state_q == B_RATE) && div_done;

  pprd_divider #(
    .NUM_W (NW),
    .DEN_W (DW)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .done_o  (div_done)
  );

  pprd_ram #(
    .WIDTH (RW),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (widx_q),
    .wdata_i (raw_sat),
    .raddr_i (sidx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // A sample without a rate update leaves directly; otherwise the result waits for the mean.
  always_comb begin
    out_push_o = 1'b0;
    out_item_o.peak_flag     = item_i.peak;
    out_item_o.rate_update   = 1'b0;
    out_item_o.raw_rate      = '0;
    out_item_o.smoothed_rate = '0;
    out_item_o.held_rate     = latest_q;
    out_item_o.dc_level_out  = item_i.dc_level;
    if (take && !item_i.update) begin
      out_push_o = 1'b1;
    end else if ((state_q == B_MEAN) && div_done) begin
      out_push_o = 1'b1;
      out_item_o.peak_flag     = cur_q.peak;
      out_item_o.rate_update   = 1'b1;
      out_item_o.raw_rate      = raw_q;
      out_item_o.smoothed_rate = div_quo[RW-1:0];
      out_item_o.held_rate     = div_quo[RW-1:0];
      out_item_o.dc_level_out  = cur_q.dc_level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      latest_q <= '0;
      widx_q   <= '0;
      fill_q   <= '0;
      sidx_q   <= '0;
      rvalid_q <= 1'b0;
    end else begin
      unique case (state_q)
        B_IDLE: begin
          if (take && item_i.update) begin
            state_q <= B_RATE;
          end
        end
        B_RATE: begin
          if (div_done) begin
            widx_q   <= (widx_q == AW'(HISTORY_DEPTH - 1)) ? '0 : widx_q + 1'b1;
            if (fill_q != FW'(HISTORY_DEPTH)) begin
              fill_q <= fill_q + 1'b1;
            end
            sidx_q   <= '0;
            rvalid_q <= 1'b0;
            state_q  <= B_SUM;
          end
        end
        B_SUM: begin
          rvalid_q <= rd_en;
          if (rd_en) begin
            sidx_q <= sidx_q + 1'b1;
          end
          if (sum_done) begin
            state_q <= B_MEAN;
          end
        end
        B_MEAN: begin
          if (div_done) begin
            latest_q <= div_quo[RW-1:0];
            state_q  <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_q <= item_i;
    end
    if (ram_we) begin
      raw_q <= raw_sat;
      sum_q <= '0;
    end else if ((state_q == B_SUM) && rvalid_q) begin
      sum_q <= sum_q + SUM_W'(ram_rdata);
    end
  end

`ifndef SYNTHESIS
  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(HISTORY_DEPTH))
    else $error("history fill count beyond depth");
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == B_RATE || state_q == B_MEAN))
    else $error("divider finished outside a waiting state");
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> !out_full_i)
    else $error("result pushed into a full queue");
  a_sum_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_SUM) |-> (fill_q != '0))
    else $error("mean taken over an empty history");
`endif

endmodule
